// ----- rtl/balloon_launch_float_detector_top_macros.svh -----
// assertion macros shared by the checker
// each expects clk and rst_n in the scope where it is used
`ifndef BALLOON_LAUNCH_FLOAT_DETECTOR_TOP_MACROS_SVH
`define BALLOON_LAUNCH_FLOAT_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define BLFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define BLFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define BLFD_ASSERT_NXT_ALL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/blfd_pkg.sv -----
package blfd_pkg;

  // ring geometry
  localparam int RING_DEPTH = 8;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // field widths
  localparam int TIME_W   = 48;
  localparam int PRES_W   = 17;
  localparam int SEC_W    = 16;
  localparam int MS_W     = 26;
  localparam int RATE_W   = 31;
  localparam int LIMIT_W  = 32;
  localparam int OP_W     = 2;
  localparam int NUM_W    = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_FIELDS_W  = TIME_W + PRES_W + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + TIME_W + 1 + 1 + 1 + RATE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int RATE_SCALE = 100000;
  localparam int MS_PER_S   = 1000;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // operations
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_COMMAND = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;
  localparam logic [OP_W-1:0] OP_INIT    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINK_LOSS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_DROP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_DEB = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_TMO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_PRES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_RATE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_HOLD = 3'd6;

  // register reset values
  localparam logic [SEC_W-1:0]   RST_LINK_LOSS_S  = 16'd600;
  localparam logic [PRES_W-1:0]  RST_LAUNCH_DROP  = 17'd500;
  localparam logic [SEC_W-1:0]   RST_LAUNCH_DEB_S = 16'd10;
  localparam logic [SEC_W-1:0]   RST_FLOAT_TMO_S  = 16'd7200;
  localparam logic [PRES_W-1:0]  RST_FLOAT_PRES   = 17'd1000;
  localparam logic [LIMIT_W-1:0] RST_FLOAT_RATE   = 32'd500;
  localparam logic [SEC_W-1:0]   RST_FLOAT_HOLD_S = 16'd60;

  // divider result towards the sequencer
  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] rate;
  } div_res_t;

endpackage

// ----- rtl/blfd_div.sv -----
module blfd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [blfd_pkg::NUM_W-1:0]    num,
  input  logic [blfd_pkg::TIME_W-1:0]   den,
  output blfd_pkg::div_res_t            res
);
  import blfd_pkg::*;

  localparam int ITER_W = $clog2(NUM_W);

  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [TIME_W-1:0] den_r, den_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [TIME_W:0]   rem_sh;
  logic [TIME_W+1:0] trial;

  // restoring division, one quotient bit a cycle, dividend shifts out of quo_r
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    iter_nxt = iter_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      iter_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[TIME_W+1]) begin
        rem_nxt = trial[TIME_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[TIME_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      iter_nxt = iter_r + 1'b1;
      if (iter_r == ITER_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    iter_r <= iter_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // quotients past the 31-bit range saturate
  assign res.done = done_r;
  assign res.rate = (|quo_r[NUM_W-1:RATE_W]) ? RATE_MAX : quo_r[RATE_W-1:0];

endmodule

// ----- rtl/balloon_launch_float_detector_top.sv -----
// sequence: command, restore and init beats go straight to the output stage; samples pass
//   read, scale, 34-step divide and check, or read and check when the rate is unavailable
// throughput: one beat at a time, the next is taken once the result is registered;
//   a full output register adds its stall
// reset: synchronous active-low rst_n clears flags, ring pointers and timers and
//   restores the register defaults; the ring memory itself is never cleared
module balloon_launch_float_detector_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input beats
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [47:0] time_ms, [64:48] pressure_pa, [65] restore_launched, rest zero
  input  logic [blfd_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] operation
  input  logic [blfd_pkg::OP_W-1:0]          in_tuser,
  // result beats
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] launched, [48:1] launch_time, [49] floating, [50] link_lost,
  // [51] link_seen, [82:52] pressure_rate, rest zero
  output logic [blfd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [blfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [blfd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import blfd_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a beat
  localparam logic [2:0] ST_RD   = 3'd1;  // oldest ring entry arrives from memory
  localparam logic [2:0] ST_MUL  = 3'd2;  // scale the pressure step, kick the divider
  localparam logic [2:0] ST_DIV  = 3'd3;  // divider running
  localparam logic [2:0] ST_FLT  = 3'd4;  // float criterion on the fresh rate
  localparam logic [2:0] ST_OUT  = 3'd5;  // hand the result to the output register

  localparam int RING_W = PRES_W + TIME_W;

  // seconds to milliseconds, done once at register write
  function automatic logic [MS_W-1:0] sec_to_ms(input logic [SEC_W-1:0] s);
    sec_to_ms = MS_W'(s) * MS_W'(MS_PER_S);
  endfunction

  // ---------------------------------------------------------------- registers
  logic [MS_W-1:0]           link_ms_r;
  logic [PRES_W-1:0]         drop_r;
  logic [MS_W-1:0]           deb_ms_r;
  logic [MS_W-1:0]           tmo_ms_r;
  logic [PRES_W-1:0]         fpres_r;
  logic signed [LIMIT_W-1:0] frate_r;
  logic [MS_W-1:0]           hold_ms_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_ms_r <= sec_to_ms(RST_LINK_LOSS_S);
      drop_r    <= RST_LAUNCH_DROP;
      deb_ms_r  <= sec_to_ms(RST_LAUNCH_DEB_S);
      tmo_ms_r  <= sec_to_ms(RST_FLOAT_TMO_S);
      fpres_r   <= RST_FLOAT_PRES;
      frate_r   <= RST_FLOAT_RATE;
      hold_ms_r <= sec_to_ms(RST_FLOAT_HOLD_S);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINK_LOSS:   link_ms_r <= sec_to_ms(cfg_data[SEC_W-1:0]);
        REG_LAUNCH_DROP: drop_r    <= cfg_data[PRES_W-1:0];
        REG_LAUNCH_DEB:  deb_ms_r  <= sec_to_ms(cfg_data[SEC_W-1:0]);
        REG_FLOAT_TMO:   tmo_ms_r  <= sec_to_ms(cfg_data[SEC_W-1:0]);
        REG_FLOAT_PRES:  fpres_r   <= cfg_data[PRES_W-1:0];
        REG_FLOAT_RATE:  frate_r   <= cfg_data[LIMIT_W-1:0];
        REG_FLOAT_HOLD:  hold_ms_r <= sec_to_ms(cfg_data[SEC_W-1:0]);
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- ring memory
  // pressure/time pairs; entries are only read once the ring is full since init,
  // so stale contents never reach a result
  logic [RING_W-1:0]  ring_mem [RING_DEPTH];
  logic               ring_we;
  logic [RING_AW-1:0] ring_wa;
  logic [RING_AW-1:0] ring_ra;
  logic [RING_W-1:0]  ring_wd;
  logic [RING_W-1:0]  ring_rd_r;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_rd_r <= ring_mem[ring_ra];
  end

  // ---------------------------------------------------------------- flight state
  logic [2:0]         state_r, state_nxt;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TIME_W-1:0]  lastcmd_r, lastcmd_nxt;
  logic               seen_r, seen_nxt;
  logic               auto_r, auto_nxt;
  logic               launch_r, launch_nxt;
  logic [TIME_W-1:0]  ltime_r, ltime_nxt;
  logic [PRES_W-1:0]  ground_r, ground_nxt;
  logic [TIME_W-1:0]  lcand_r, lcand_nxt;
  logic               float_r, float_nxt;
  logic [TIME_W-1:0]  fcand_r, fcand_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;

  // per-sample working registers
  logic [PRES_W-1:0]  samp_p_r, samp_p_nxt;
  logic [TIME_W-1:0]  samp_t_r, samp_t_nxt;
  logic               fchk_r, fchk_nxt;     // float criterion applies to this sample
  logic [PRES_W-1:0]  dp_r, dp_nxt;
  logic [TIME_W-1:0]  dt_r, dt_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // divider
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  div_res_t           div_res;

  blfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dt_r),
    .res   (div_res)
  );

  // input fields
  logic [TIME_W-1:0] in_t;
  logic [PRES_W-1:0] in_p;
  logic              in_rl;
  logic              in_acc;

  assign in_t   = in_tdata[TIME_W-1:0];
  assign in_p   = in_tdata[TIME_W +: PRES_W];
  assign in_rl  = in_tdata[TIME_W + PRES_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;

  // sample bookkeeping that does not need the rate
  logic [RING_AW-1:0] head_inc;
  logic [PRES_W-1:0]  ground_max;
  logic [PRES_W:0]    drop_sum;
  logic               drop_hit;
  logic [TIME_W-1:0]  lcand_eff;
  logic [TIME_W-1:0]  since_cmd, since_lcand, since_launch;

  assign head_inc     = (head_r == RING_AW'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign ground_max   = (in_p > ground_r) ? in_p : ground_r;
  assign drop_sum     = {1'b0, in_p} + {1'b0, drop_r};
  assign drop_hit     = (ground_max != '0) && (drop_sum <= {1'b0, ground_max});
  assign lcand_eff    = (lcand_r == '0) ? in_t : lcand_r;
  // elapsed times wrap modulo 2^48
  assign since_cmd    = in_t - lastcmd_r;
  assign since_lcand  = in_t - lcand_eff;
  assign since_launch = in_t - ltime_r;

  // rate path
  logic [TIME_W-1:0] old_t;
  logic [PRES_W-1:0] old_p;
  logic [TIME_W-1:0] dt_w;
  logic              ring_full;

  assign old_t     = ring_rd_r[TIME_W-1:0];
  assign old_p     = ring_rd_r[TIME_W +: PRES_W];
  assign dt_w      = samp_t_r - old_t;
  assign ring_full = (count_r == CNT_W'(RING_DEPTH));
  assign div_num   = NUM_W'(dp_r) * NUM_W'(RATE_SCALE);
  assign div_start = (state_r == ST_MUL);

  // float criterion
  logic [TIME_W-1:0] fcand_eff;
  logic [TIME_W-1:0] since_fcand;
  logic              fcrit;

  assign fcand_eff   = (fcand_r == '0) ? samp_t_r : fcand_r;
  assign since_fcand = samp_t_r - fcand_eff;
  assign fcrit       = (samp_p_r < fpres_r) && ($signed({1'b0, rate_r}) < frate_r);

  // memory port drive: write the new sample, read the entry that becomes oldest
  assign ring_we = in_acc && (in_tuser == OP_SAMPLE);
  assign ring_wa = head_r;
  assign ring_wd = {in_p, in_t};
  assign ring_ra = head_inc;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    lastcmd_nxt = lastcmd_r;
    seen_nxt    = seen_r;
    auto_nxt    = auto_r;
    launch_nxt  = launch_r;
    ltime_nxt   = ltime_r;
    ground_nxt  = ground_r;
    lcand_nxt   = lcand_r;
    float_nxt   = float_r;
    fcand_nxt   = fcand_r;
    rate_nxt    = rate_r;
    samp_p_nxt  = samp_p_r;
    samp_t_nxt  = samp_t_r;
    fchk_nxt    = fchk_r;
    dp_nxt      = dp_r;
    dt_nxt      = dt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_OUT;
          unique case (in_tuser)
            OP_SAMPLE: begin
              state_nxt  = ST_RD;
              samp_p_nxt = in_p;
              samp_t_nxt = in_t;
              head_nxt   = head_inc;
              if (!ring_full) begin
                count_nxt = count_r + 1'b1;
              end
              if (!auto_r && (since_cmd > TIME_W'(link_ms_r))) begin
                auto_nxt = 1'b1;
              end
              fchk_nxt = 1'b0;
              if (!launch_r) begin
                // ground tracking and launch debounce
                ground_nxt = ground_max;
                if (drop_hit) begin
                  lcand_nxt = lcand_eff;
                  if (since_lcand >= TIME_W'(deb_ms_r)) begin
                    launch_nxt = 1'b1;
                    ltime_nxt  = in_t;
                  end
                end else begin
                  lcand_nxt = '0;
                end
              end else if (!float_r) begin
                // timeout fallback, otherwise the rate decides later
                if (since_launch >= TIME_W'(tmo_ms_r)) begin
                  float_nxt = 1'b1;
                end else begin
                  fchk_nxt = 1'b1;
                end
              end
            end
            OP_COMMAND: begin
              lastcmd_nxt = in_t;
              seen_nxt    = 1'b1;
              auto_nxt    = 1'b0;
            end
            OP_RESTORE: begin
              launch_nxt = in_rl;
              ltime_nxt  = in_t;
            end
            default: begin  // init keeps the registers
              head_nxt    = '0;
              count_nxt   = '0;
              lastcmd_nxt = in_t;
              seen_nxt    = 1'b0;
              auto_nxt    = 1'b0;
              launch_nxt  = 1'b0;
              ltime_nxt   = '0;
              ground_nxt  = '0;
              lcand_nxt   = '0;
              float_nxt   = 1'b0;
              fcand_nxt   = '0;
              rate_nxt    = RATE_MAX;
            end
          endcase
        end
      end
      ST_RD: begin
        // rate is unavailable until the ring is full or over a zero span
        if (!ring_full || (dt_w == '0)) begin
          rate_nxt  = RATE_MAX;
          state_nxt = ST_FLT;
        end else begin
          dp_nxt    = (samp_p_r >= old_p) ? samp_p_r - old_p : old_p - samp_p_r;
          dt_nxt    = dt_w;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) begin
          rate_nxt  = div_res.rate;
          state_nxt = ST_FLT;
        end
      end
      ST_FLT: begin
        if (fchk_r) begin
          if (fcrit) begin
            fcand_nxt = fcand_eff;
            if (since_fcand >= TIME_W'(hold_ms_r)) begin
              float_nxt = 1'b1;
            end
          end else begin
            fcand_nxt = '0;
          end
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // wait for room in the output register
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({rate_r, seen_r, auto_r, float_r, ltime_r, launch_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    samp_p_r   <= samp_p_nxt;
    samp_t_r   <= samp_t_nxt;
    dp_r       <= dp_nxt;
    dt_r       <= dt_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      lastcmd_r   <= '0;
      seen_r      <= 1'b0;
      auto_r      <= 1'b0;
      launch_r    <= 1'b0;
      ltime_r     <= '0;
      ground_r    <= '0;
      lcand_r     <= '0;
      float_r     <= 1'b0;
      fcand_r     <= '0;
      rate_r      <= RATE_MAX;
      fchk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      lastcmd_r   <= lastcmd_nxt;
      seen_r      <= seen_nxt;
      auto_r      <= auto_nxt;
      launch_r    <= launch_nxt;
      ltime_r     <= ltime_nxt;
      ground_r    <= ground_nxt;
      lcand_r     <= lcand_nxt;
      float_r     <= float_nxt;
      fcand_r     <= fcand_nxt;
      rate_r      <= rate_nxt;
      fchk_r      <= fchk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/blfd_checker.sv -----
`include "balloon_launch_float_detector_top_macros.svh"

module blfd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [blfd_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import blfd_pkg::*;

  // one beat in flight: the block is busy right after taking a beat
  `BLFD_ASSERT_NXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready, "beat taken while busy")

  // a stalled result holds its value
  `BLFD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed under stall")

  // a new result never appears in the cycle after the input side was open
  `BLFD_ASSERT_IMP(a_out_after_work, $rose(out_tvalid), !$past(in_tready), "result without work")

  // reset empties the output register
  `BLFD_ASSERT_NXT_ALL(a_reset_empty, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind balloon_launch_float_detector_top blfd_checker u_blfd_checker (.*);
